>>> hdl/snstep_pkg.sv
package snstep_pkg;

    // field widths
    localparam int NODE_W   = 16;
    localparam int WGT_W    = 16;
    localparam int STATE_W  = 24;
    localparam int RATE_W   = 16;
    localparam int SENS_W   = 16;
    localparam int JUMP_W   = 14;
    localparam int WGTS_W   = 64;
    localparam int CFG_IDX_W = 3;

    // number of node inputs that take part in the weighted sum
    localparam int INPUT_COUNT = 4;
    localparam int NODE_PORTS  = 4;
    localparam int K_W = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 2 * NODE_W + ((INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 0);
    localparam int CUR_W   = ACC_W - 8;
    localparam int WIDE_W  = 36;
    localparam int SQ_W    = 33;

    // input queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // 0.04 in Q0.16 and 140 in Q.10
    localparam logic signed [MUL_B_W-1:0] V2_COEF     = 25'sd2621;
    localparam logic signed [WIDE_W-1:0]  V_CONST_Q10 = 36'sd143360;

    // register reset values
    localparam logic [RATE_W-1:0]         RST_RECOVERY_RATE        = 16'd1311;
    localparam logic [SENS_W-1:0]         RST_RECOVERY_SENSITIVITY = 16'd3277;
    localparam logic signed [STATE_W-1:0] RST_RESET_POTENTIAL      = -24'sd66560;
    localparam logic [JUMP_W-1:0]         RST_RECOVERY_JUMP        = 14'd8192;
    localparam logic signed [STATE_W-1:0] RST_FIRE_THRESHOLD       = 24'sd30720;
    localparam logic signed [STATE_W-1:0] RST_INITIAL_POTENTIAL    = -24'sd66560;
    localparam logic signed [STATE_W-1:0] RST_INITIAL_RECOVERY     = -24'sd15360;
    localparam logic [WGTS_W-1:0]         RST_INPUT_WEIGHTS        = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECOVERY_RATE        = 3'd0,
        REG_RECOVERY_SENSITIVITY = 3'd1,
        REG_RESET_POTENTIAL      = 3'd2,
        REG_RECOVERY_JUMP        = 3'd3,
        REG_FIRE_THRESHOLD       = 3'd4,
        REG_INITIAL_POTENTIAL    = 3'd5,
        REG_INITIAL_RECOVERY     = 3'd6,
        REG_INPUT_WEIGHTS        = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_STEP   = 1'b0,
        OP_RELOAD = 1'b1
    } op_t;

    typedef logic signed [NODE_W-1:0] node_t;

    typedef struct packed {
        op_t                       op;
        node_t [INPUT_COUNT-1:0]   node;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0]         recovery_rate;
        logic [SENS_W-1:0]         recovery_sensitivity;
        logic signed [STATE_W-1:0] reset_potential;
        logic [JUMP_W-1:0]         recovery_jump;
        logic signed [STATE_W-1:0] fire_threshold;
        logic signed [STATE_W-1:0] initial_potential;
        logic signed [STATE_W-1:0] initial_recovery;
        logic [WGTS_W-1:0]         input_weights;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WGT,
        ST_SQR,
        ST_HI,
        ST_LO,
        ST_VB,
        ST_BU,
        ST_DU,
        ST_UPD,
        ST_FIN
    } state_t;

    // clamp a wide signed value to the 24-bit state range
    function automatic logic signed [STATE_W-1:0] sat24(input logic signed [WIDE_W-1:0] x);
        logic signed [STATE_W-1:0] r;
        if ((&x[WIDE_W-1:STATE_W-1]) || !(|x[WIDE_W-1:STATE_W-1])) begin
            r = x[STATE_W-1:0];
        end
        else if (x[WIDE_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> hdl/snstep_front.sv
module snstep_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [15:0]       node_value_0,
    input  logic signed [15:0]       node_value_1,
    input  logic signed [15:0]       node_value_2,
    input  logic signed [15:0]       node_value_3,
    output logic                     q_valid,
    input  logic                     q_ready,
    output snstep_pkg::item_t        q_item
);
    import snstep_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    node_t               port_vals [NODE_PORTS];
    item_t               item_in;
    logic                push;
    logic                pop;

    // gather node ports
    assign port_vals[0] = node_value_0;
    assign port_vals[1] = node_value_1;
    assign port_vals[2] = node_value_2;
    assign port_vals[3] = node_value_3;

    // classify the transaction and keep only the active inputs
    always_comb
    begin
        item_in.op = action ? OP_RELOAD : OP_STEP;
        for (int k = 0; k < INPUT_COUNT; k++)
        begin
            item_in.node[k] = port_vals[k];
        end
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/snstep_back.sv
module snstep_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  snstep_pkg::cfg_t         cfg,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  snstep_pkg::item_t        q_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     fired,
    output logic signed [23:0]       potential_now,
    output logic signed [23:0]       recovery_now
);
    import snstep_pkg::*;

    state_t                      state_reg, state_next;
    logic [K_W-1:0]              k_reg, k_next;
    node_t [INPUT_COUNT-1:0]     nodes_reg, nodes_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [22:0]                 lo_reg, lo_next;
    logic [35:0]                 hp_reg, hp_next;
    logic [SQ_W-1:0]             sq_reg, sq_next;
    logic signed [MUL_A_W-1:0]   bmu_reg, bmu_next;
    logic signed [WIDE_W-1:0]    vsum_reg, vsum_next;
    logic signed [STATE_W-1:0]   vn_reg, vn_next;
    logic signed [STATE_W-1:0]   v_reg, v_next;
    logic signed [STATE_W-1:0]   u_reg, u_next;
    logic                        fired_reg, fired_next;
    logic                        out_vld_reg, out_vld_next;
    logic                        out_fired_reg, out_fired_next;
    logic signed [STATE_W-1:0]   out_v_reg, out_v_next;
    logic signed [STATE_W-1:0]   out_u_reg, out_u_next;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]     prod_acc;
    logic [58:0]                 sq_total;
    logic signed [MUL_A_W-1:0]   bv;
    logic signed [MUL_A_W:0]     bmu_wide;
    logic signed [WIDE_W-1:0]    vx;
    logic signed [WIDE_W-1:0]    ux;
    logic signed [WIDE_W-1:0]    curx;
    logic signed [WIDE_W-1:0]    sqx;
    logic signed [27:0]          du;
    logic signed [STATE_W-1:0]   un;
    logic signed [STATE_W-1:0]   u_fin;
    logic signed [WGT_W-1:0]     w_k;

    // shared multiplier operand select
    always_comb
    begin
        w_k = signed'(cfg.input_weights[WGT_W*k_reg +: WGT_W]);
        case (state_reg)
            ST_WGT:
            begin
                mul_a = MUL_A_W'(signed'(nodes_reg[k_reg]));
                mul_b = MUL_B_W'(w_k);
            end
            ST_SQR:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(v_reg);
            end
            ST_HI:
            begin
                mul_a = signed'({3'b000, prod_reg[46:23]});
                mul_b = V2_COEF;
            end
            ST_LO:
            begin
                mul_a = signed'({4'b0000, lo_reg});
                mul_b = V2_COEF;
            end
            ST_VB:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = signed'({9'b0, cfg.recovery_sensitivity});
            end
            ST_DU:
            begin
                mul_a = bmu_reg;
                mul_b = signed'({9'b0, cfg.recovery_rate});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // arithmetic on the registered product
    always_comb
    begin
        prod_acc = prod_reg[ACC_W-1:0];
        sq_total = {hp_reg, 23'b0} + 59'(prod_reg[34:0]);
        bv       = prod_reg[40:14];
        bmu_wide = (MUL_A_W + 1)'(bv) - (MUL_A_W + 1)'(u_reg);
        vx       = WIDE_W'(v_reg);
        ux       = WIDE_W'(u_reg);
        curx     = WIDE_W'(signed'(acc_reg[ACC_W-1:8]));
        sqx      = signed'(WIDE_W'(sq_reg));
        du       = prod_reg[43:16];
        un       = sat24(WIDE_W'(u_reg) + WIDE_W'(du));
        u_fin    = fired_reg ? sat24(ux + signed'(WIDE_W'(cfg.recovery_jump))) : u_reg;
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        nodes_next     = nodes_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hp_next        = hp_reg;
        sq_next        = sq_reg;
        bmu_next       = bmu_reg;
        vsum_next      = vsum_reg;
        vn_next        = vn_reg;
        v_next         = v_reg;
        u_next         = u_reg;
        fired_next     = fired_reg;
        out_vld_next   = out_vld_reg && !out_ready;
        out_fired_next = out_fired_reg;
        out_v_next     = out_v_reg;
        out_u_next     = out_u_reg;
        q_ready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready    = 1'b1;
                    nodes_next = q_item.node;
                    if (q_item.op == OP_RELOAD)
                    begin
                        v_next     = cfg.initial_potential;
                        u_next     = cfg.initial_recovery;
                        fired_next = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = ST_WGT;
                    end
                end
            end
            ST_WGT:
            begin
                // the previous input's product is added from the product register
                if (k_reg != '0)
                begin
                    acc_next = acc_reg + prod_acc;
                end
                if (k_reg == K_W'(INPUT_COUNT - 1))
                begin
                    state_next = ST_SQR;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SQR:
            begin
                acc_next   = acc_reg + prod_acc;
                state_next = ST_HI;
            end
            ST_HI:
            begin
                lo_next    = prod_reg[22:0];
                state_next = ST_LO;
            end
            ST_LO:
            begin
                hp_next    = prod_reg[35:0];
                state_next = ST_VB;
            end
            ST_VB:
            begin
                // 0.04 v^2 in Q.10
                sq_next    = sq_total[58:26];
                state_next = ST_BU;
            end
            ST_BU:
            begin
                bmu_next   = bmu_wide[MUL_A_W-1:0];
                // v + dv, with 5v + v folded into 6v
                vsum_next  = sqx + (vx <<< 2) + (vx <<< 1) + V_CONST_Q10 - ux + curx;
                state_next = ST_DU;
            end
            ST_DU:
            begin
                vn_next    = sat24(vsum_reg);
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                u_next = un;
                if (vn_reg >= cfg.fire_threshold)
                begin
                    fired_next = 1'b1;
                    v_next     = cfg.reset_potential;
                end
                else
                begin
                    fired_next = 1'b0;
                    v_next     = vn_reg;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hand over once the output register is free
                if (!out_vld_reg || out_ready)
                begin
                    u_next         = u_fin;
                    out_vld_next   = 1'b1;
                    out_fired_next = fired_reg;
                    out_v_next     = v_reg;
                    out_u_next     = u_fin;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and neuron state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            v_reg       <= RST_INITIAL_POTENTIAL;
            u_reg       <= RST_INITIAL_RECOVERY;
            fired_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            v_reg       <= v_next;
            u_reg       <= u_next;
            fired_reg   <= fired_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= PROD_W'(mul_a) * PROD_W'(mul_b);
        nodes_reg     <= nodes_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        hp_reg        <= hp_next;
        sq_reg        <= sq_next;
        bmu_reg       <= bmu_next;
        vsum_reg      <= vsum_next;
        vn_reg        <= vn_next;
        out_fired_reg <= out_fired_next;
        out_v_reg     <= out_v_next;
        out_u_reg     <= out_u_next;
    end

    assign out_valid     = out_vld_reg;
    assign fired         = out_fired_reg;
    assign potential_now = out_v_reg;
    assign recovery_now  = out_u_reg;

    // checks
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue popped outside idle");

    a_fire_resets_v: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_fired_reg |-> out_v_reg == cfg.reset_potential)
        else $error("spike result without reset potential");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside final state");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && out_vld_reg && !out_ready |=> state_reg == ST_FIN)
        else $error("result dropped while output stalled");

endmodule

>>> hdl/spiking_neuron_step.sv
// Fixed-point spiking neuron, one Euler step per transaction. An advance
// transaction forms the weighted input current from the node values and
// steps V and U (Q13.10, saturated); a reload transaction restores the
// initial V and U and reports fired as 0. Every transaction returns one
// result. A two-entry queue takes transactions while the neuron works;
// the neuron itself handles one at a time with a single shared 27x25
// multiplier, and a result may wait on out_ready. Registers are
// written through the configuration channel, which is always ready; the
// user must write them only while no transaction is in flight, as the
// block itself does not enforce it.
module spiking_neuron_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic signed [15:0]  node_value_0,
    input  logic signed [15:0]  node_value_1,
    input  logic signed [15:0]  node_value_2,
    input  logic signed [15:0]  node_value_3,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                fired,
    output logic signed [23:0]  potential_now,
    output logic signed [23:0]  recovery_now
);
    import snstep_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid;
    logic   q_ready;
    item_t  q_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.recovery_rate        <= RST_RECOVERY_RATE;
            cfg_reg.recovery_sensitivity <= RST_RECOVERY_SENSITIVITY;
            cfg_reg.reset_potential      <= RST_RESET_POTENTIAL;
            cfg_reg.recovery_jump        <= RST_RECOVERY_JUMP;
            cfg_reg.fire_threshold       <= RST_FIRE_THRESHOLD;
            cfg_reg.initial_potential    <= RST_INITIAL_POTENTIAL;
            cfg_reg.initial_recovery     <= RST_INITIAL_RECOVERY;
            cfg_reg.input_weights        <= RST_INPUT_WEIGHTS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RECOVERY_RATE:        cfg_reg.recovery_rate        <= cfg_data[RATE_W-1:0];
                REG_RECOVERY_SENSITIVITY: cfg_reg.recovery_sensitivity <= cfg_data[SENS_W-1:0];
                REG_RESET_POTENTIAL:      cfg_reg.reset_potential      <= cfg_data[STATE_W-1:0];
                REG_RECOVERY_JUMP:        cfg_reg.recovery_jump        <= cfg_data[JUMP_W-1:0];
                REG_FIRE_THRESHOLD:       cfg_reg.fire_threshold       <= cfg_data[STATE_W-1:0];
                REG_INITIAL_POTENTIAL:    cfg_reg.initial_potential    <= cfg_data[STATE_W-1:0];
                REG_INITIAL_RECOVERY:     cfg_reg.initial_recovery     <= cfg_data[STATE_W-1:0];
                REG_INPUT_WEIGHTS:        cfg_reg.input_weights        <= cfg_data[WGTS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input side: accept and classify, queue
    snstep_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .node_value_0 (node_value_0),
        .node_value_1 (node_value_1),
        .node_value_2 (node_value_2),
        .node_value_3 (node_value_3),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    // neuron update and result register
    snstep_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired         (fired),
        .potential_now (potential_now),
        .recovery_now  (recovery_now)
    );

endmodule
